// File: src/dwl_pkg.sv
// Shared types, constants and the D4 coefficient table for the wavelet line core.
// Used by the controller, the datapath and the top level; depends on nothing.
package dwl_pkg;

	localparam int DATA_BITS = 24;
	localparam int MAX_LINE  = 64;
	localparam int ADDR_BITS = $clog2(MAX_LINE);
	localparam int LINE_LOG2 = ADDR_BITS;
	localparam int CNT_BITS  = ADDR_BITS + 1;
	localparam int LG_BITS   = 3;
	localparam int COEF_BITS = 16;
	localparam int PROD_BITS = DATA_BITS + COEF_BITS;
	localparam int ACC_BITS  = PROD_BITS + 2;
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH_LOG2  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_MODE = 4'd1;

	localparam logic signed [COEF_BITS-1:0] K0 = 16'sd15826;
	localparam logic signed [COEF_BITS-1:0] K1 = 16'sd27411;
	localparam logic signed [COEF_BITS-1:0] K2 = 16'sd7345;
	localparam logic signed [COEF_BITS-1:0] K3 = -16'sd4240;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] sample;
		logic                        line_end;
	} dwl_in_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] value;
		logic                        last;
	} dwl_out_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FILL,
		ST_LEVEL,
		ST_DRAIN,
		ST_COPY,
		ST_OUT
	} dwl_state_t;

	// Commands from the controller to the datapath, one set per cycle.
	typedef struct packed {
		logic                        line_we;
		logic                        line_wzero;
		logic [ADDR_BITS-1:0]        line_waddr;
		logic [ADDR_BITS-1:0]        line_raddr;
		logic [ADDR_BITS-1:0]        work_raddr;
		logic                        tap_valid;
		logic                        tap_first;
		logic                        tap_last;
		logic signed [COEF_BITS-1:0] coef;
		logic [ADDR_BITS-1:0]        dest;
		logic                        copy_rd;
		logic                        out_rd;
		logic                        out_last;
	} dwl_cmd_t;

	// Coefficient for one tap. The second flag selects the detail output of a
	// forward level or the odd output of an inverse level.
	function automatic logic signed [COEF_BITS-1:0] tap_coef(input logic inv,
			input logic alt, input logic [1:0] tap);
		logic signed [COEF_BITS-1:0] c;
		c = K0;
		case ({inv, alt, tap})
			4'b00_00: c = K0;
			4'b00_01: c = K1;
			4'b00_10: c = K2;
			4'b00_11: c = K3;
			4'b01_00: c = K3;
			4'b01_01: c = -K2;
			4'b01_10: c = K1;
			4'b01_11: c = -K0;
			4'b10_00: c = K2;
			4'b10_01: c = K1;
			4'b10_10: c = K0;
			4'b10_11: c = K3;
			4'b11_00: c = K3;
			4'b11_01: c = -K0;
			4'b11_10: c = K1;
			4'b11_11: c = -K2;
			default:  c = K0;
		endcase
		return c;
	endfunction

endpackage

// File: src/dwl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the line store and the work store.
module dwl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/dwl_ctrl.sv
// Controller for the wavelet line core: loading, level sequencing, copy and readout.
// Depends on dwl_pkg; drives the datapath through dwl_cmd_t.
module dwl_ctrl
	import dwl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     line_end,
	output logic                     busy,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output dwl_cmd_t                 cmd
);

	dwl_state_t           state_q, state_d;
	logic [CNT_BITS-1:0]  cnt_q, cnt_d;
	logic [CNT_BITS-1:0]  ptr_q, ptr_d;
	logic [ADDR_BITS-1:0] j_q, j_d;
	logic [1:0]           t_q, t_d;
	logic [LG_BITS-1:0]   lvl_q, lvl_d;
	logic [1:0]           drain_q, drain_d;
	logic [LG_BITS-1:0]   len_log2_q;
	logic                 inv_q;

	logic [LG_BITS-1:0]   eff_lg;
	logic [CNT_BITS-1:0]  len;
	logic [CNT_BITS-1:0]  nn;
	logic [ADDR_BITS-1:0] nmask, hmask, nh;
	logic [ADDR_BITS-1:0] fi, ii, ip, tap_addr;
	logic                 alt;
	logic                 accept;
	logic [CNT_BITS-1:0]  cnt_inc;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;

	// Length clamped to the supported range.
	always_comb begin
		if (len_log2_q < LG_BITS'(2)) begin
			eff_lg = LG_BITS'(2);
		end else if (len_log2_q > LG_BITS'(LINE_LOG2)) begin
			eff_lg = LG_BITS'(LINE_LOG2);
		end else begin
			eff_lg = len_log2_q;
		end
	end
	assign len = CNT_BITS'(1) << eff_lg;

	// Level geometry and tap addressing.
	assign nn      = CNT_BITS'(1) << lvl_q;
	assign nmask   = ADDR_BITS'(nn - CNT_BITS'(1));
	assign nh      = ADDR_BITS'(nn >> 1);
	assign hmask   = nh - ADDR_BITS'(1);
	assign fi      = j_q & hmask;
	assign ii      = j_q >> 1;
	assign ip      = (ii + nh - ADDR_BITS'(1)) & hmask;
	assign alt     = inv_q ? j_q[0] : ((j_q & nh) != '0);
	assign cnt_inc = cnt_q + CNT_BITS'(1);

	always_comb begin
		if (!inv_q) begin
			tap_addr = ((fi << 1) + ADDR_BITS'(t_q)) & nmask;
		end else begin
			case (t_q)
				2'd0:    tap_addr = ip;
				2'd1:    tap_addr = ip + nh;
				2'd2:    tap_addr = ii;
				default: tap_addr = ii + nh;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_log2_q <= LG_BITS'(6);
			inv_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LENGTH_LOG2) begin
				len_log2_q <= cfg_data[LG_BITS-1:0];
			end else if (cfg_index == REG_INVERSE_MODE) begin
				inv_q <= cfg_data[0];
			end
		end
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ptr_q   <= '0;
			j_q     <= '0;
			t_q     <= '0;
			lvl_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
			j_q     <= j_d;
			t_q     <= t_d;
			lvl_q   <= lvl_d;
			drain_q <= drain_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ptr_d   = ptr_q;
		j_d     = j_q;
		t_d     = t_q;
		lvl_d   = lvl_q;
		drain_d = drain_q;

		cmd            = '0;
		cmd.coef       = tap_coef(inv_q, alt, t_q);
		cmd.line_raddr = tap_addr;
		cmd.dest       = j_q;
		cmd.work_raddr = ptr_q[ADDR_BITS-1:0];
		cmd.line_waddr = cnt_q[ADDR_BITS-1:0];

		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					cmd.line_we = (cnt_q < len);
					if (cnt_q >= len || cnt_inc == len || line_end) begin
						// Line complete: zero-fill any gap, then transform.
						j_d   = '0;
						t_d   = '0;
						lvl_d = inv_q ? LG_BITS'(2) : eff_lg;
						cnt_d = '0;
						if (cnt_q < len && cnt_inc < len) begin
							ptr_d   = cnt_inc;
							state_d = ST_FILL;
						end else begin
							state_d = ST_LEVEL;
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			ST_FILL: begin
				cmd.line_we    = 1'b1;
				cmd.line_wzero = 1'b1;
				cmd.line_waddr = ptr_q[ADDR_BITS-1:0];
				ptr_d          = ptr_q + CNT_BITS'(1);
				if (ptr_q + CNT_BITS'(1) == len) begin
					state_d = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				cmd.tap_valid = 1'b1;
				cmd.tap_first = (t_q == 2'd0);
				cmd.tap_last  = (t_q == 2'd3);
				t_d           = t_q + 2'd1;
				if (t_q == 2'd3) begin
					j_d = j_q + ADDR_BITS'(1);
					if (j_q == nmask) begin
						j_d     = '0;
						drain_d = '0;
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// Let the last sums reach the work store.
				drain_d = drain_q + 2'd1;
				if (drain_q == 2'd2) begin
					ptr_d   = '0;
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				// A spare step at the end keeps the last write off the next read.
				cmd.copy_rd = (ptr_q < nn);
				ptr_d       = ptr_q + CNT_BITS'(1);
				if (ptr_q == nn) begin
					ptr_d = '0;
					if (inv_q ? (lvl_q == eff_lg) : (lvl_q == LG_BITS'(2))) begin
						state_d = ST_OUT;
					end else begin
						lvl_d   = inv_q ? lvl_q + LG_BITS'(1) : lvl_q - LG_BITS'(1);
						state_d = ST_LEVEL;
					end
				end
			end
			ST_OUT: begin
				cmd.out_rd     = 1'b1;
				cmd.line_raddr = ptr_q[ADDR_BITS-1:0];
				cmd.out_last   = (ptr_q + CNT_BITS'(1) == len);
				ptr_d          = ptr_q + CNT_BITS'(1);
				if (ptr_q + CNT_BITS'(1) == len) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// File: src/dwl_dp.sv
// Datapath for the wavelet line core: both stores, the shared MAC, rounding and saturation.
// Depends on dwl_pkg and dwl_ram; driven by dwl_ctrl through dwl_cmd_t.
module dwl_dp
	import dwl_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  dwl_cmd_t                    cmd,
	input  logic signed [DATA_BITS-1:0] sample,
	output dwl_out_t                    result,
	output logic                        result_strobe
);

	localparam int RND_BITS = ACC_BITS + 1;
	localparam int Q_BITS   = RND_BITS - 15;

	logic [DATA_BITS-1:0]        line_rdata, work_rdata, line_wdata, work_wdata;
	logic                        line_we;
	logic [ADDR_BITS-1:0]        line_waddr;

	logic                        tap_s1, first_s1, last_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic [ADDR_BITS-1:0]        dest_s1, dest_s2, dest_s3;
	logic                        tap_s2, first_s2, last_s2;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  sum_s3;
	logic                        wr_s3;
	logic                        copy_s1;
	logic [ADDR_BITS-1:0]        copy_addr_s1;
	logic                        out_s1, out_last_s1;

	logic signed [RND_BITS-1:0]  rnd;
	logic signed [Q_BITS-1:0]    q;
	logic signed [DATA_BITS-1:0] sat;

	// Line store write: copy-back has priority over load and zero fill.
	assign line_we    = copy_s1 || cmd.line_we;
	assign line_waddr = copy_s1 ? copy_addr_s1 : cmd.line_waddr;
	assign line_wdata = copy_s1 ? work_rdata :
		(cmd.line_wzero ? '0 : DATA_BITS'(sample));

	dwl_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LINE)) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(line_wdata),
		.raddr(cmd.line_raddr),
		.rdata(line_rdata)
	);

	dwl_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LINE)) u_work (
		.clk  (clk),
		.we   (wr_s3),
		.waddr(dest_s3),
		.wdata(work_wdata),
		.raddr(cmd.work_raddr),
		.rdata(work_rdata)
	);

	// Control flags that follow the RAM read latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1  <= 1'b0;
			tap_s2  <= 1'b0;
			wr_s3   <= 1'b0;
			copy_s1 <= 1'b0;
			out_s1  <= 1'b0;
		end else begin
			tap_s1  <= cmd.tap_valid;
			tap_s2  <= tap_s1;
			wr_s3   <= tap_s2 && last_s2;
			copy_s1 <= cmd.copy_rd;
			out_s1  <= cmd.out_rd;
		end
	end

	// Tap pipeline: read, multiply, accumulate over four taps.
	always_ff @(posedge clk) begin
		first_s1     <= cmd.tap_first;
		last_s1      <= cmd.tap_last;
		coef_s1      <= cmd.coef;
		dest_s1      <= cmd.dest;
		copy_addr_s1 <= cmd.work_raddr;
		out_last_s1  <= cmd.out_last;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		dest_s2  <= dest_s1;
		prod_s2  <= $signed(line_rdata) * coef_s1;

		if (tap_s2) begin
			if (first_s2) begin
				acc_q <= ACC_BITS'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s2);
			end
		end
		sum_s3  <= acc_q + ACC_BITS'(prod_s2);
		dest_s3 <= dest_s2;
	end

	// Round half up, then saturate to the data range.
	always_comb begin
		rnd = RND_BITS'(sum_s3) + RND_BITS'(16384);
		q   = Q_BITS'(rnd >>> 15);
		if (q > Q_BITS'(2 ** (DATA_BITS - 1) - 1)) begin
			sat = {1'b0, {(DATA_BITS-1){1'b1}}};
		end else if (q < -Q_BITS'(2 ** (DATA_BITS - 1))) begin
			sat = {1'b1, {(DATA_BITS-1){1'b0}}};
		end else begin
			sat = DATA_BITS'(q);
		end
	end
	assign work_wdata = sat;

	assign result_strobe = out_s1;
	assign result.value  = $signed(line_rdata);
	assign result.last   = out_last_s1;

endmodule

// File: src/daubechies4_wavelet_line_core.sv
// Top level of the Daubechies D4 line transform core.
// Depends on dwl_pkg, dwl_ctrl, dwl_dp and dwl_ram.

// A line of L = 4..64 samples is loaded one sample per cycle while start is
// high and busy is low; it ends after L samples or on line_end. The core then
// raises busy, zero-fills any unloaded tail, runs every D4 level forward or
// inverse on one shared multiply-accumulate unit and emits the L results on
// consecutive cycles, each marked by result_strobe for one cycle with last on
// the final one. The receiver cannot stall, so it must take every transfer.
// Each level sums its taps on the MAC, drains the last sums into the work
// store and then copies them back to the line store.
module daubechies4_wavelet_line_core
	import dwl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  dwl_in_t                  item,
	output dwl_out_t                 result,
	output logic                     result_strobe,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	dwl_cmd_t cmd;

	dwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.line_end (item.line_end),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd)
	);

	dwl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (item.sample),
		.result       (result),
		.result_strobe(result_strobe)
	);

endmodule
